// File: hdl/sabs_pkg.sv
package sabs_pkg;

   localparam int AddrWidth = 64;
   localparam int DataWidth = 64;

   // funct3 low bits select the access size
   localparam logic [1:0] SIZE_CODE_MASK = 2'h3;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_STORE = 1'b1;

   localparam logic [1:0] CLASS_LOAD  = 2'd1;
   localparam logic [1:0] CLASS_STORE = 2'd2;

   // csr word index (byte address bit 2)
   localparam logic REG_BOUNDARY = 1'b0;
   localparam logic REG_MISALIGN = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_BAD_CLASS  = 2'd1,
      STATUS_MISALIGNED = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REM,
      ST_SEG
   } back_state_type;

   typedef struct packed {
      logic                   cmd;
      logic [1:0]             inst_class;
      logic [1:0]             width_code;
      logic signed [11:0]     offset_imm;
      logic [AddrWidth-1:0]   base_value;
      logic [DataWidth-1:0]   data_value;
   } req_payload_type;

   typedef struct packed {
      status_type             status;
      logic [AddrWidth-1:0]   seg_addr;
      logic [3:0]             seg_size;
      logic [2:0]             byte_lane;
      logic [DataWidth-1:0]   seg_data;
      logic                   last;
   } rsp_payload_type;

   typedef struct packed {
      logic [7:0] boundary_size;
      logic       misalign_trap_enable;
   } cfg_type;

   // classified access as it travels from front to back
   typedef struct packed {
      status_type             status;
      logic                   cmd;
      logic [3:0]             size;
      logic [AddrWidth-1:0]   addr;
      logic [DataWidth-1:0]   data;
   } op_type;

   function automatic logic [DataWidth-1:0] byte_mask(input logic [3:0] nbytes);
      logic [DataWidth-1:0] m;
      m = '0;
      for (int i = 0; i < DataWidth / 8; i++) begin
         m[8*i +: 8] = (4'(i) < nbytes) ? 8'hFF : 8'h00;
      end
      return m;
   endfunction

endpackage

// File: hdl/sabs_front.sv
module sabs_front (
   input  sabs_pkg::req_payload_type req,
   input  sabs_pkg::cfg_type         cfg,
   output sabs_pkg::op_type          op
);
   import sabs_pkg::*;

   logic [1:0]           wcode;
   logic [AddrWidth-1:0] addr;
   logic [3:0]           size;
   logic [2:0]           low_mask;
   logic                 class_ok;
   logic                 misaligned;

   always_comb begin
      wcode    = req.width_code & SIZE_CODE_MASK;
      addr     = req.base_value + {{(AddrWidth-12){req.offset_imm[11]}}, req.offset_imm};
      size     = 4'd1 << wcode;
      low_mask = 3'(size - 4'd1);
      class_ok = ((req.cmd == CMD_LOAD)  && (req.inst_class == CLASS_LOAD)) ||
                 ((req.cmd == CMD_STORE) && (req.inst_class == CLASS_STORE));
      misaligned = cfg.misalign_trap_enable && ((addr[2:0] & low_mask) != 3'd0);

      op.cmd  = req.cmd;
      op.size = size;
      op.addr = addr;
      op.data = req.data_value;
      priority if (!class_ok) begin
         op.status = STATUS_BAD_CLASS;
      end else if (misaligned) begin
         op.status = STATUS_MISALIGNED;
      end else begin
         op.status = STATUS_OK;
      end
   end

endmodule

// File: hdl/sabs_queue.sv
module sabs_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sabs_pkg::op_type  push_op,
   output logic              full,
   input  logic              pop,
   output sabs_pkg::op_type  pop_op,
   output logic              empty
);
   import sabs_pkg::*;

   op_type     slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;

   assign full   = (count_ff == 2'd2);
   assign empty  = (count_ff == 2'd0);
   assign pop_op = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("pop from empty queue");

endmodule

// File: hdl/sabs_back.sv
module sabs_back (
   input  logic                      clock,
   input  logic                      reset,
   input  sabs_pkg::cfg_type         cfg,
   input  sabs_pkg::op_type          q_op,
   input  logic                      q_empty,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output sabs_pkg::rsp_payload_type rsp_payload
);
   import sabs_pkg::*;

   back_state_type       state_ff, state_in;
   op_type               op_ff, op_in;
   logic [7:0]           rem_ff, rem_in;
   logic [2:0]           chunk_ff, chunk_in;
   logic [AddrWidth-1:0] cur_ff, cur_in;
   logic [3:0]           remaining_ff, remaining_in;
   logic [2:0]           offset_ff, offset_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_ff, rsp_in;

   logic                 out_free;
   logic [7:0]           room;
   logic [AddrWidth-1:0] inv_cur;
   logic                 wrap;
   logic [7:0]           room_eff;
   logic [3:0]           seg;
   logic [3:0]           left;
   logic [7:0]           chunk_byte;
   logic [7:0]           rem_step;
   logic [8:0]           trial;
   logic [7:0]           rem_sum;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign out_free    = !rsp_valid_ff || !rsp_stall;

   // segment sizing against the boundary and the top of the address space
   always_comb begin
      room     = cfg.boundary_size - rem_ff;
      inv_cur  = ~cur_ff;
      wrap     = (inv_cur[AddrWidth-1:8] == '0) && (inv_cur[7:0] < (room - 8'd1));
      room_eff = wrap ? (inv_cur[7:0] + 8'd1) : room;
      if (cfg.boundary_size == 8'd0) begin
         seg = remaining_ff;
      end else if (room_eff < {4'd0, remaining_ff}) begin
         seg = room_eff[3:0];
      end else begin
         seg = remaining_ff;
      end
      left    = remaining_ff - seg;
      rem_sum = rem_ff + {4'd0, seg};
   end

   // eight bits of the address folded into the remainder per cycle
   always_comb begin
      chunk_byte = op_ff.addr[{~chunk_ff, 3'b000} +: 8];
      rem_step   = rem_ff;
      for (int i = 7; i >= 0; i--) begin
         trial = {rem_step, chunk_byte[i]};
         if (trial >= {1'b0, cfg.boundary_size}) begin
            trial = trial - {1'b0, cfg.boundary_size};
         end
         rem_step = trial[7:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      rem_in       = rem_ff;
      chunk_in     = chunk_ff;
      cur_in       = cur_ff;
      remaining_in = remaining_ff;
      offset_in    = offset_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      q_pop        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop        = 1'b1;
               op_in        = q_op;
               cur_in       = q_op.addr;
               remaining_in = q_op.size;
               offset_in    = 3'd0;
               rem_in       = 8'd0;
               chunk_in     = 3'd0;
               if ((q_op.status == STATUS_OK) && (cfg.boundary_size != 8'd0)) begin
                  state_in = ST_REM;
               end else begin
                  state_in = ST_SEG;
               end
            end
         end
         ST_REM: begin
            rem_in   = rem_step;
            chunk_in = chunk_ff + 3'd1;
            if (chunk_ff == 3'd7) begin
               state_in = ST_SEG;
            end
         end
         ST_SEG: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (op_ff.status != STATUS_OK) begin
                  rsp_in.status     = op_ff.status;
                  rsp_in.seg_addr   = '0;
                  rsp_in.seg_size   = 4'd0;
                  rsp_in.byte_lane  = 3'd0;
                  rsp_in.seg_data   = '0;
                  rsp_in.last       = 1'b1;
                  state_in          = ST_IDLE;
               end else begin
                  rsp_in.status     = STATUS_OK;
                  rsp_in.seg_addr   = cur_ff;
                  rsp_in.seg_size   = seg;
                  rsp_in.byte_lane  = offset_ff;
                  rsp_in.seg_data   = (op_ff.cmd == CMD_STORE) ?
                     ((op_ff.data >> {offset_ff, 3'b000}) & byte_mask(seg)) : '0;
                  rsp_in.last       = (left == 4'd0);
                  remaining_in      = left;
                  offset_in         = offset_ff + seg[2:0];
                  cur_in            = cur_ff + AddrWidth'(seg);
                  // wrapping to address zero or reaching the boundary restarts the region
                  if ((wrap && ({4'd0, seg} == room_eff)) ||
                      (rem_sum == cfg.boundary_size)) begin
                     rem_in = 8'd0;
                  end else begin
                     rem_in = rem_sum;
                  end
                  if (left == 4'd0) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      rem_ff       <= rem_in;
      chunk_ff     <= chunk_in;
      cur_ff       <= cur_in;
      remaining_ff <= remaining_in;
      offset_ff    <= offset_in;
      rsp_ff       <= rsp_in;
   end

   a_rem_below_boundary: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEG && op_ff.status == STATUS_OK && cfg.boundary_size != 8'd0)
      |-> (rem_ff < cfg.boundary_size))
      else $error("remainder not below boundary");

   a_error_single_beat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status != STATUS_OK)
      |-> (rsp_ff.last && rsp_ff.seg_size == 4'd0))
      else $error("error beat is not a single empty last beat");

endmodule

// File: hdl/scalar_access_boundary_splitter_core.sv
// channel   | direction | handshake              | payload
// req       | in        | req_valid / req_stall  | req_payload (req_payload_type)
// rsp       | out       | rsp_valid / rsp_stall  | rsp_payload (rsp_payload_type)
// csr       | in/out    | psel, penable, pready  | 3-bit paddr, 32-bit pwdata/prdata
//
// a beat enters the front, is classified and address-summed in the same cycle and
// lands in a two-deep queue; req_stall rises only when that queue is full
// the back pops one access, then with a nonzero boundary folds the
// address into a remainder, one address byte per cycle
// after that it emits one segment beat per cycle while rsp is not stalled, 1 to 8
// beats; errors and a zero boundary skip the remainder and give a single beat
// a stalled rsp beat holds in the output register while the queue keeps filling
// synchronous active-high reset empties the queue and clears both csr fields
module scalar_access_boundary_splitter_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  sabs_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output sabs_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [2:0]                csr_paddr,
   input  logic [31:0]               csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);
   import sabs_pkg::*;

   // configuration registers
   logic [7:0] boundary_ff, boundary_in;
   logic       misalign_ff, misalign_in;
   logic       csr_write;
   cfg_type    cfg;

   // front to queue to back
   op_type     front_op;
   op_type     q_op;
   logic       q_full;
   logic       q_empty;
   logic       q_pop;
   logic       q_push;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   assign cfg.boundary_size        = boundary_ff;
   assign cfg.misalign_trap_enable = misalign_ff;

   // word index sits in address bit 2
   always_comb begin
      boundary_in = boundary_ff;
      misalign_in = misalign_ff;
      unique case (csr_paddr[2])
         REG_BOUNDARY: begin
            csr_prdata = {24'd0, boundary_ff};
            if (csr_write) begin
               boundary_in = csr_pwdata[7:0];
            end
         end
         REG_MISALIGN: begin
            csr_prdata = {31'd0, misalign_ff};
            if (csr_write) begin
               misalign_in = csr_pwdata[0];
            end
         end
         default: begin
            csr_prdata = 32'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         boundary_ff <= 8'd0;
         misalign_ff <= 1'b0;
      end else begin
         boundary_ff <= boundary_in;
         misalign_ff <= misalign_in;
      end
   end

   // accept whenever the queue has a free slot
   assign req_stall = q_full;
   assign q_push    = req_valid && !q_full;

   sabs_front u_front (
      .req (req_payload),
      .cfg (cfg),
      .op  (front_op)
   );

   sabs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .push_op (front_op),
      .full    (q_full),
      .pop     (q_pop),
      .pop_op  (q_op),
      .empty   (q_empty)
   );

   sabs_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .q_op        (q_op),
      .q_empty     (q_empty),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
   import sabs_pkg::*;

   // predicts the segment beats of each accepted access and checks them in order
   class split_scoreboard;
      logic [7:0]      boundary;
      logic            trap_on;
      rsp_payload_type expected_beats[$];
      int              mismatches;

      function new();
         boundary   = '0;
         trap_on    = 1'b0;
         mismatches = 0;
      endfunction

      function void expect_beat(rsp_payload_type r);
         expected_beats = {expected_beats, r};
      endfunction

      function rsp_payload_type fault_beat(status_type st);
         rsp_payload_type r;
         r        = '0;
         r.status = st;
         r.last   = 1'b1;
         return r;
      endfunction

      function void note_access(req_payload_type p);
         logic [63:0]     addr, cur, nbytes, remaining, offset, room, seg, bnd, mask;
         rsp_payload_type r;
         bit              class_ok;
         class_ok = (p.cmd == CMD_LOAD && p.inst_class == CLASS_LOAD) ||
                    (p.cmd == CMD_STORE && p.inst_class == CLASS_STORE);
         if (!class_ok) begin
            expect_beat(fault_beat(STATUS_BAD_CLASS));
            return;
         end
         addr   = p.base_value + {{52{p.offset_imm[11]}}, p.offset_imm};
         nbytes = 64'd1 << p.width_code;
         if (trap_on && (addr & (nbytes - 64'd1)) != 64'd0) begin
            expect_beat(fault_beat(STATUS_MISALIGNED));
            return;
         end
         bnd       = 64'(boundary);
         cur       = addr;
         remaining = nbytes;
         offset    = '0;
         while (remaining != 0) begin
            if (bnd == 0) begin
               // no split, even across the top of the address space
               room = remaining;
            end else begin
               room = bnd - (cur % bnd);
               // address zero acts as a boundary too
               if (~cur < room - 64'd1) room = ~cur + 64'd1;
            end
            seg        = (room < remaining) ? room : remaining;
            remaining -= seg;
            mask       = (seg >= 8) ? '1 : ((64'd1 << (8 * seg)) - 64'd1);
            r.status     = STATUS_OK;
            r.seg_addr   = cur;
            r.seg_size   = seg[3:0];
            r.byte_lane  = offset[2:0];
            r.seg_data   = (p.cmd == CMD_STORE) ? ((p.data_value >> (8 * offset)) & mask) : '0;
            r.last       = (remaining == 0);
            expect_beat(r);
            cur    += seg;
            offset += seg;
         end
      endfunction

      function void report(string what, rsp_payload_type want, rsp_payload_type got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("%s: exp st=%0d addr=%h sz=%0d off=%0d data=%h last=%b", what,
                     want.status, want.seg_addr, want.seg_size, want.byte_lane,
                     want.seg_data, want.last);
            $display("   got st=%0d addr=%h sz=%0d off=%0d data=%h last=%b",
                     got.status, got.seg_addr, got.seg_size, got.byte_lane,
                     got.seg_data, got.last);
         end
      endfunction

      function void check_beat(rsp_payload_type got);
         rsp_payload_type want;
         if (expected_beats.size() == 0) begin
            report("unexpected beat", '0, got);
            return;
         end
         want = expected_beats.pop_front();
         if (got.status !== want.status || got.seg_addr !== want.seg_addr ||
             got.seg_size !== want.seg_size || got.byte_lane !== want.byte_lane ||
             got.seg_data !== want.seg_data || got.last !== want.last) begin
            report("mismatch", want, got);
         end
      endfunction
   endclass

   // access sizes as carried in the low funct3 bits
   localparam logic [1:0] W_BYTE   = 2'd0;
   localparam logic [1:0] W_HALF   = 2'd1;
   localparam logic [1:0] W_WORD   = 2'd2;
   localparam logic [1:0] W_DOUBLE = 2'd3;

   // decoded classes that never match a command
   localparam logic [1:0] CLASS_OTHER    = 2'd0;
   localparam logic [1:0] CLASS_RESERVED = 2'd3;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid;
   logic            req_stall;
   req_payload_type req_payload;
   logic            rsp_valid;
   logic            rsp_stall;
   rsp_payload_type rsp_payload;
   logic            csr_psel;
   logic            csr_penable;
   logic            csr_pwrite;
   logic [2:0]      csr_paddr;
   logic [31:0]     csr_pwdata;
   logic [31:0]     csr_prdata;
   logic            csr_pready;

   // when set, neither side inserts gaps or stalls
   bit calm = 1'b0;

   split_scoreboard sb = new();

   scalar_access_boundary_splitter_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side: random stall, changed only on the falling edge
   always @(negedge clock) begin
      rsp_stall = !calm && ($urandom_range(99, 0) < 7);
   end

   // every accepted result beat goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_beat(rsp_payload);
   end

   // apb write: setup cycle, then access cycle until pready
   task automatic csr_write(logic reg_sel, logic [31:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {reg_sel, 2'b00};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      if (reg_sel == REG_BOUNDARY) sb.boundary = value[7:0];
      else sb.trap_on = value[0];
   endtask

   // only called with the block idle
   task automatic set_mode(logic [7:0] bnd, logic trap);
      csr_write(REG_BOUNDARY, 32'(bnd));
      csr_write(REG_MISALIGN, 32'(trap));
   endtask

   // one beat on the request side; valid stays high into the next call
   // unless a random gap lowers it
   task automatic drive_access(req_payload_type p);
      @(negedge clock);
      req_valid   = 1'b1;
      req_payload = p;
      do @(posedge clock); while (req_stall);
      sb.note_access(p);
      if (!calm && $urandom_range(99, 0) < 7) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(3, 0)) @(negedge clock);
      end
   endtask

   // stop sending and wait for every predicted beat
   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.expected_beats.size() != 0) @(posedge clock);
   endtask

   function automatic req_payload_type make_access(logic cmd, logic [1:0] cls,
                                                  logic [1:0] wc, logic [11:0] imm,
                                                  logic [63:0] base, logic [63:0] data);
      req_payload_type p;
      p.cmd        = cmd;
      p.inst_class = cls;
      p.width_code = wc;
      p.offset_imm = imm;
      p.base_value = base;
      p.data_value = data;
      return p;
   endfunction

   // mostly well-formed accesses, a share of class mismatches as noise
   function automatic req_payload_type draw_access();
      req_payload_type p;
      logic [63:0]     imm_ext;
      p.cmd = 1'($urandom_range(1, 0));
      if ($urandom_range(99, 0) < 85) begin
         p.inst_class = (p.cmd == CMD_STORE) ? CLASS_STORE : CLASS_LOAD;
      end else begin
         p.inst_class = 2'($urandom_range(3, 0));
      end
      p.width_code = 2'($urandom_range(3, 0));
      p.offset_imm = 12'($urandom);
      p.data_value = {$urandom, $urandom};
      case ($urandom_range(3, 0))
         0: p.base_value = {$urandom, $urandom};
         1: begin
            // just below the top so the access may wrap to zero
            p.base_value = ~64'($urandom_range(40, 0));
            p.offset_imm = 12'($urandom_range(15, 0));
         end
         2: p.base_value = 64'($urandom_range(4095, 0));
         default: begin
            // effective address aligned to eight bytes
            imm_ext      = {{52{p.offset_imm[11]}}, p.offset_imm};
            p.base_value = ({$urandom, $urandom} & ~64'h7) - imm_ext;
         end
      endcase
      return p;
   endfunction

   task automatic random_phase(logic [7:0] bnd, logic trap, bit quiet, int count);
      calm = quiet;
      set_mode(bnd, trap);
      repeat (count) drive_access(draw_access());
      drain();
      calm = 1'b0;
   endtask

   initial begin
      req_valid   = 1'b0;
      req_payload = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: no split, no alignment trap
      drive_access(make_access(CMD_LOAD, CLASS_LOAD, W_BYTE, 12'h000, 64'd0, '1));
      // whole double wraps past the top as a single segment
      drive_access(make_access(CMD_STORE, CLASS_STORE, W_DOUBLE, 12'h000,
                               64'hFFFF_FFFF_FFFF_FFFC, 64'h0123_4567_89AB_CDEF));
      // most negative immediate from base zero
      drive_access(make_access(CMD_STORE, CLASS_STORE, W_DOUBLE, 12'h800, 64'd0, '1));
      // largest immediate from the top address
      drive_access(make_access(CMD_LOAD, CLASS_LOAD, W_HALF, 12'h7FF, '1, '1));
      // five of the six pairings of command and class that do not match
      drive_access(make_access(CMD_LOAD, CLASS_OTHER, W_WORD, 12'h000, 64'd0, '0));
      drive_access(make_access(CMD_LOAD, CLASS_STORE, W_WORD, 12'h000, 64'd0, '0));
      drive_access(make_access(CMD_LOAD, CLASS_RESERVED, W_WORD, 12'h000, 64'd0, '0));
      drive_access(make_access(CMD_STORE, CLASS_LOAD, W_BYTE, 12'hFFF, '1, '1));
      drive_access(make_access(CMD_STORE, CLASS_RESERVED, W_BYTE, 12'hFFF, '1, '1));
      drain();

      // boundary that is not a power of two
      set_mode(8'd3, 1'b0);
      drive_access(make_access(CMD_STORE, CLASS_STORE, W_DOUBLE, 12'h000, 64'd1,
                               64'h0123_4567_89AB_CDEF));
      // segments run to the top and carry on at address zero
      drive_access(make_access(CMD_STORE, CLASS_STORE, W_DOUBLE, 12'h000,
                               64'hFFFF_FFFF_FFFF_FFFD, 64'hFEDC_BA98_7654_3210));
      drive_access(make_access(CMD_LOAD, CLASS_LOAD, W_WORD, 12'hFFF, 64'd5, '1));
      drain();

      // byte boundary with the alignment trap on
      set_mode(8'd1, 1'b1);
      drive_access(make_access(CMD_STORE, CLASS_STORE, W_DOUBLE, 12'h000, 64'd8,
                               64'h8877_6655_4433_2211));
      drive_access(make_access(CMD_LOAD, CLASS_LOAD, W_WORD, 12'h000, 64'd1, '0));
      // class check wins over a misaligned address
      drive_access(make_access(CMD_STORE, CLASS_LOAD, W_HALF, 12'h000, 64'd1, '1));
      drive_access(make_access(CMD_LOAD, CLASS_LOAD, W_DOUBLE, 12'h7FF, 64'd0, '0));
      drain();

      // largest boundary
      set_mode(8'd255, 1'b0);
      drive_access(make_access(CMD_STORE, CLASS_STORE, W_DOUBLE, 12'h000, 64'd250,
                               64'h0123_4567_89AB_CDEF));
      drive_access(make_access(CMD_STORE, CLASS_STORE, W_WORD, 12'h000,
                               64'hFFFF_FFFF_FFFF_FFFE, 64'hA5A5_5A5A_C3C3_3C3C));
      drive_access(make_access(CMD_LOAD, CLASS_LOAD, W_BYTE, 12'h000, '1, '0));
      drain();

      // random accesses over a spread of settings; one phase runs with no gaps
      random_phase(8'd0, 1'b0, 1'b0, 36);
      random_phase(8'd1, 1'b1, 1'b0, 36);
      random_phase(8'd255, 1'b0, 1'b0, 36);
      random_phase(8'd3, 1'b1, 1'b0, 36);
      random_phase(8'd2, 1'b0, 1'b1, 50);
      random_phase(8'd7, 1'b0, 1'b0, 36);
      random_phase(8'd8, 1'b1, 1'b0, 36);
      random_phase(8'd5, 1'b0, 1'b0, 36);
      random_phase(8'($urandom_range(255, 1)), 1'($urandom_range(1, 0)), 1'b0, 20);

      // let any stray beat show up before the verdict
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.expected_beats.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
